// ===== design/nir_pkg.sv =====
// ----------------------------------------------------------------------------
// NEC IR frame decoder package
// Shared widths, timing windows, symbol classes and register indexes.
// ----------------------------------------------------------------------------
package nir_pkg;

  localparam int TIME_W    = 32;
  localparam int CLK_W     = 8;
  localparam int BYTE_W    = 8;
  localparam int BIT_IDX_W = 3;

  // Register indexes on the configuration port.
  localparam logic REG_TIMER_PERIOD = 1'b0;
  localparam logic REG_CLOCK_SPEED  = 1'b1;

  localparam logic [TIME_W-1:0] TIMER_PERIOD_RST = 32'd65536;
  localparam logic [CLK_W-1:0]  CLOCK_SPEED_RST  = 8'd1;

  // Timing windows in microseconds, both bounds exclusive.
  localparam logic [TIME_W-1:0] LEAD_MARK_LO  = 32'd8750;
  localparam logic [TIME_W-1:0] LEAD_MARK_HI  = 32'd9250;
  localparam logic [TIME_W-1:0] LEAD_SPACE_LO = 32'd4250;
  localparam logic [TIME_W-1:0] LEAD_SPACE_HI = 32'd4750;
  localparam logic [TIME_W-1:0] REP_SPACE_LO  = 32'd2250;
  localparam logic [TIME_W-1:0] REP_SPACE_HI  = 32'd2750;
  localparam logic [TIME_W-1:0] BIT_SHORT_LO  = 32'd500;
  localparam logic [TIME_W-1:0] BIT_SHORT_HI  = 32'd600;
  localparam logic [TIME_W-1:0] BIT_LONG_LO   = 32'd1500;
  localparam logic [TIME_W-1:0] BIT_LONG_HI   = 32'd1800;

  localparam logic MSG_FRAME  = 1'b0;
  localparam logic MSG_REPEAT = 1'b1;

  typedef enum logic [2:0] {
    CLS_LEADIN,
    CLS_REPEAT,
    CLS_ONE,
    CLS_ZERO,
    CLS_OTHER
  } sym_cls_t;

endpackage

// ===== design/nec_ir_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// NEC IR frame decoder
// Decodes NEC remote frames and repeat codes from timer capture triples.
// ----------------------------------------------------------------------------
// Each input item carries three capture timestamps of one mark/space pair on
// in_valid/in_stall. The front end turns both durations into microseconds
// with two 32-step serial dividers and classifies the pair; a two-entry queue
// feeds the back end, which runs the frame state machine on each popped
// item and loads the result into an output register on out_valid/out_stall.
// No new item is taken until the last one has passed its accept cycle, the
// divider steps, the classify cycle and its queue write, which waits while
// the queue is full. While the receiver stalls, the result register holds
// and the queue absorbs up to two further items before the front end stalls
// its input. Configuration writes on cfg_valid/cfg_ready are always taken;
// index 0 sets the timer period, index 1 the ticks per microsecond. The user
// must see that they are made only while the block is idle; the block does
// not enforce this. Synchronous reset restores both registers to their
// defaults, empties the queue and returns to waiting for a lead-in.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder
  import nir_pkg::*;
#(
  parameter int BITS_PER_FIELD = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [TIME_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TIME_W-1:0] start_time,
  input  logic [TIME_W-1:0] mid_time,
  input  logic [TIME_W-1:0] end_time,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              msg_kind,
  output logic [BYTE_W-1:0] address,
  output logic [BYTE_W-1:0] address_inv,
  output logic [BYTE_W-1:0] command,
  output logic [BYTE_W-1:0] command_inv,
  output logic [BYTE_W-1:0] repeat_count,
  output logic [BYTE_W-1:0] address_err,
  output logic [BYTE_W-1:0] address_inv_err,
  output logic [BYTE_W-1:0] command_err,
  output logic [BYTE_W-1:0] command_inv_err
);

  logic [TIME_W-1:0] timer_period;
  logic [CLK_W-1:0]  clock_speed;
  logic              push;
  sym_cls_t          push_cls;
  logic              q_full;
  logic              pop;
  sym_cls_t          pop_cls;
  logic              q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period <= TIMER_PERIOD_RST;
      clock_speed  <= CLOCK_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIMER_PERIOD: timer_period <= cfg_data;
        REG_CLOCK_SPEED:  clock_speed  <= cfg_data[CLK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  nir_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .start_time   (start_time),
    .mid_time     (mid_time),
    .end_time     (end_time),
    .timer_period (timer_period),
    .clock_speed  (clock_speed),
    .push         (push),
    .push_cls     (push_cls),
    .q_full       (q_full)
  );

  nir_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cls (push_cls),
    .full     (q_full),
    .pop      (pop),
    .pop_cls  (pop_cls),
    .empty    (q_empty)
  );

  nir_back #(
    .BITS_PER_FIELD (BITS_PER_FIELD)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .empty           (q_empty),
    .pop             (pop),
    .pop_cls         (pop_cls),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .msg_kind        (msg_kind),
    .address         (address),
    .address_inv     (address_inv),
    .command         (command),
    .command_inv     (command_inv),
    .repeat_count    (repeat_count),
    .address_err     (address_err),
    .address_inv_err (address_inv_err),
    .command_err     (command_err),
    .command_inv_err (command_inv_err)
  );

endmodule

// ===== design/nir_div.sv =====
// ----------------------------------------------------------------------------
// NEC IR serial divider
// Restoring divider, one quotient bit per cycle, 32-bit by 8-bit.
// ----------------------------------------------------------------------------
module nir_div
  import nir_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [CLK_W-1:0]  divisor,
  output logic              done,
  output logic [TIME_W-1:0] quotient
);

  localparam int CNT_W = $clog2(TIME_W);

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [TIME_W-1:0] quo;
  logic [CLK_W-1:0]  rem;
  logic [CLK_W-1:0]  dvs;
  logic [CLK_W:0]    shifted;
  logic [CLK_W:0]    diff;
  logic              ge;
  logic [CLK_W-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, quo[TIME_W-1]};
    diff     = shifted - {1'b0, dvs};
    ge       = shifted >= {1'b0, dvs};
    rem_next = ge ? diff[CLK_W-1:0] : shifted[CLK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == '0);
      if (start) begin
        run <= 1'b1;
      end else if (run && (cnt == '0)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      cnt <= CNT_W'(TIME_W - 1);
    end else if (run) begin
      quo <= {quo[TIME_W-2:0], ge};
      rem <= rem_next;
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient = quo;

endmodule

// ===== design/nir_front.sv =====
// ----------------------------------------------------------------------------
// NEC IR front end
// Accepts timestamp items, measures mark and space in microseconds and
// classifies the pair into a symbol class for the back end.
// ----------------------------------------------------------------------------
module nir_front
  import nir_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TIME_W-1:0] start_time,
  input  logic [TIME_W-1:0] mid_time,
  input  logic [TIME_W-1:0] end_time,
  input  logic [TIME_W-1:0] timer_period,
  input  logic [CLK_W-1:0]  clock_speed,
  output logic              push,
  output sym_cls_t          push_cls,
  input  logic              q_full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t      state;
  sym_cls_t          cls;
  logic              accept;
  logic [CLK_W-1:0]  divisor;
  logic [TIME_W-1:0] lo_ticks;
  logic [TIME_W-1:0] hi_ticks;
  logic              lo_done;
  logic              hi_done;
  logic [TIME_W-1:0] lo_us;
  logic [TIME_W-1:0] hi_us;

  function automatic logic [TIME_W-1:0] wrap_ticks(input logic [TIME_W-1:0] t0,
                                                   input logic [TIME_W-1:0] t1,
                                                   input logic [TIME_W-1:0] period);
    logic [TIME_W-1:0] r;
    if (t0 > t1) begin
      r = period - t0 + t1;
    end else begin
      r = t1 - t0;
    end
    return r;
  endfunction

  function automatic logic in_window(input logic [TIME_W-1:0] v,
                                     input logic [TIME_W-1:0] lo,
                                     input logic [TIME_W-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

  function automatic sym_cls_t classify(input logic [TIME_W-1:0] lo,
                                        input logic [TIME_W-1:0] hi);
    logic     lead;
    logic     short_mark;
    sym_cls_t c;
    lead       = in_window(lo, LEAD_MARK_LO, LEAD_MARK_HI);
    short_mark = in_window(lo, BIT_SHORT_LO, BIT_SHORT_HI);
    if (lead && in_window(hi, LEAD_SPACE_LO, LEAD_SPACE_HI)) begin
      c = CLS_LEADIN;
    end else if (lead && in_window(hi, REP_SPACE_LO, REP_SPACE_HI)) begin
      c = CLS_REPEAT;
    end else if (short_mark && in_window(hi, BIT_LONG_LO, BIT_LONG_HI)) begin
      c = CLS_ONE;
    end else if (short_mark && in_window(hi, BIT_SHORT_LO, BIT_SHORT_HI)) begin
      c = CLS_ZERO;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

  assign in_stall = (state != F_IDLE);
  assign accept   = in_valid && !in_stall;
  assign divisor  = (clock_speed == '0) ? CLK_W'(1) : clock_speed;
  assign lo_ticks = wrap_ticks(start_time, mid_time, timer_period);
  assign hi_ticks = wrap_ticks(mid_time, end_time, timer_period);
  assign push     = (state == F_PUSH) && !q_full;
  assign push_cls = cls;

  nir_div u_lo_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (lo_ticks),
    .divisor  (divisor),
    .done     (lo_done),
    .quotient (lo_us)
  );

  nir_div u_hi_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (hi_ticks),
    .divisor  (divisor),
    .done     (hi_done),
    .quotient (hi_us)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (lo_done && hi_done) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == F_DIV) && lo_done && hi_done) begin
      cls <= classify(lo_us, hi_us);
    end
  end

endmodule

// ===== design/nir_queue.sv =====
// ----------------------------------------------------------------------------
// NEC IR symbol queue
// Two-entry queue of symbol classes between the front and back ends.
// ----------------------------------------------------------------------------
module nir_queue
  import nir_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  sym_cls_t push_cls,
  output logic     full,
  input  logic     pop,
  output sym_cls_t pop_cls,
  output logic     empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  sym_cls_t           mem [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [PTR_W:0]     count;

  assign full    = (count == (PTR_W+1)'(DEPTH));
  assign empty   = (count == '0);
  assign pop_cls = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_cls;
    end
  end

endmodule

// ===== design/nir_back.sv =====
// ----------------------------------------------------------------------------
// NEC IR back end
// Runs the frame state machine on symbol classes and holds the result item
// in an output register.
// ----------------------------------------------------------------------------
module nir_back
  import nir_pkg::*;
#(
  parameter int BITS_PER_FIELD = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  output logic              pop,
  input  sym_cls_t          pop_cls,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              msg_kind,
  output logic [BYTE_W-1:0] address,
  output logic [BYTE_W-1:0] address_inv,
  output logic [BYTE_W-1:0] command,
  output logic [BYTE_W-1:0] command_inv,
  output logic [BYTE_W-1:0] repeat_count,
  output logic [BYTE_W-1:0] address_err,
  output logic [BYTE_W-1:0] address_inv_err,
  output logic [BYTE_W-1:0] command_err,
  output logic [BYTE_W-1:0] command_inv_err
);

  typedef enum logic [4:0] {
    PH_LEADIN   = 5'b00001,
    PH_ADDR     = 5'b00010,
    PH_ADDR_INV = 5'b00100,
    PH_CMD      = 5'b01000,
    PH_CMD_INV  = 5'b10000
  } phase_t;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_FIELD - 1);

  phase_t               phase, phase_next;
  logic [BIT_IDX_W-1:0] bit_index, bit_index_next;
  logic [BYTE_W-1:0]    addr_bits, addr_bits_next;
  logic [BYTE_W-1:0]    addr_inv_bits, addr_inv_bits_next;
  logic [BYTE_W-1:0]    cmd_bits, cmd_bits_next;
  logic [BYTE_W-1:0]    cmd_inv_bits, cmd_inv_bits_next;
  logic [BYTE_W-1:0]    addr_err_mask, addr_err_mask_next;
  logic [BYTE_W-1:0]    addr_inv_err_mask, addr_inv_err_mask_next;
  logic [BYTE_W-1:0]    cmd_err_mask, cmd_err_mask_next;
  logic [BYTE_W-1:0]    cmd_inv_err_mask, cmd_inv_err_mask_next;
  logic [BYTE_W-1:0]    repeats, repeats_next;
  logic                 emit;
  logic                 kind;
  logic [BYTE_W-1:0]    mask;
  logic [BYTE_W-1:0]    data_or;
  logic [BYTE_W-1:0]    err_or;

  assign pop     = !empty && (!out_valid || !out_stall);
  assign mask    = BYTE_W'(1) << bit_index;
  assign data_or = (pop_cls == CLS_ONE) ? mask : '0;
  assign err_or  = ((pop_cls == CLS_ONE) || (pop_cls == CLS_ZERO)) ? '0 : mask;

  always_comb begin
    phase_next             = phase;
    bit_index_next         = bit_index;
    addr_bits_next         = addr_bits;
    addr_inv_bits_next     = addr_inv_bits;
    cmd_bits_next          = cmd_bits;
    cmd_inv_bits_next      = cmd_inv_bits;
    addr_err_mask_next     = addr_err_mask;
    addr_inv_err_mask_next = addr_inv_err_mask;
    cmd_err_mask_next      = cmd_err_mask;
    cmd_inv_err_mask_next  = cmd_inv_err_mask;
    repeats_next           = repeats;
    emit                   = 1'b0;
    kind                   = MSG_FRAME;
    case (phase)
      PH_ADDR: begin
        addr_bits_next     = addr_bits | data_or;
        addr_err_mask_next = addr_err_mask | err_or;
      end
      PH_ADDR_INV: begin
        addr_inv_bits_next     = addr_inv_bits | data_or;
        addr_inv_err_mask_next = addr_inv_err_mask | err_or;
      end
      PH_CMD: begin
        cmd_bits_next     = cmd_bits | data_or;
        cmd_err_mask_next = cmd_err_mask | err_or;
      end
      PH_CMD_INV: begin
        cmd_inv_bits_next     = cmd_inv_bits | data_or;
        cmd_inv_err_mask_next = cmd_inv_err_mask | err_or;
      end
      default: begin
      end
    endcase
    if (phase == PH_LEADIN) begin
      case (pop_cls)
        CLS_LEADIN: begin
          phase_next             = PH_ADDR;
          bit_index_next         = '0;
          addr_bits_next         = '0;
          addr_inv_bits_next     = '0;
          cmd_bits_next          = '0;
          cmd_inv_bits_next      = '0;
          addr_err_mask_next     = '0;
          addr_inv_err_mask_next = '0;
          cmd_err_mask_next      = '0;
          cmd_inv_err_mask_next  = '0;
          repeats_next           = '0;
        end
        CLS_REPEAT: begin
          if (repeats != '1) begin
            repeats_next = repeats + 1'b1;
          end
          emit = 1'b1;
          kind = MSG_REPEAT;
        end
        default: begin
        end
      endcase
    end else if (bit_index == LAST_BIT) begin
      bit_index_next = '0;
      case (phase)
        PH_ADDR:     phase_next = PH_ADDR_INV;
        PH_ADDR_INV: phase_next = PH_CMD;
        PH_CMD:      phase_next = PH_CMD_INV;
        default: begin
          phase_next = PH_LEADIN;
          emit       = 1'b1;
          kind       = MSG_FRAME;
        end
      endcase
    end else begin
      bit_index_next = bit_index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_LEADIN;
      bit_index         <= '0;
      addr_bits         <= '0;
      addr_inv_bits     <= '0;
      cmd_bits          <= '0;
      cmd_inv_bits      <= '0;
      addr_err_mask     <= '0;
      addr_inv_err_mask <= '0;
      cmd_err_mask      <= '0;
      cmd_inv_err_mask  <= '0;
      repeats           <= '0;
    end else if (pop) begin
      phase             <= phase_next;
      bit_index         <= bit_index_next;
      addr_bits         <= addr_bits_next;
      addr_inv_bits     <= addr_inv_bits_next;
      cmd_bits          <= cmd_bits_next;
      cmd_inv_bits      <= cmd_inv_bits_next;
      addr_err_mask     <= addr_err_mask_next;
      addr_inv_err_mask <= addr_inv_err_mask_next;
      cmd_err_mask      <= cmd_err_mask_next;
      cmd_inv_err_mask  <= cmd_inv_err_mask_next;
      repeats           <= repeats_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && out_stall) || (pop && emit);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      msg_kind        <= kind;
      address         <= addr_bits_next;
      address_inv     <= addr_inv_bits_next;
      command         <= cmd_bits_next;
      command_inv     <= cmd_inv_bits_next;
      repeat_count    <= repeats_next;
      address_err     <= addr_err_mask_next;
      address_inv_err <= addr_inv_err_mask_next;
      command_err     <= cmd_err_mask_next;
      command_inv_err <= cmd_inv_err_mask_next;
    end
  end

endmodule

// ===== design/nir_checker.sv =====
// ----------------------------------------------------------------------------
// NEC IR frame decoder checker
// Port-level properties of the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module nir_checker
  import nir_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic              msg_kind,
  input logic [BYTE_W-1:0] address,
  input logic [BYTE_W-1:0] address_inv,
  input logic [BYTE_W-1:0] command,
  input logic [BYTE_W-1:0] command_inv,
  input logic [BYTE_W-1:0] repeat_count,
  input logic [BYTE_W-1:0] address_err,
  input logic [BYTE_W-1:0] address_inv_err,
  input logic [BYTE_W-1:0] command_err,
  input logic [BYTE_W-1:0] command_inv_err
);

  // A stalled result item stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(address) && $stable(command)
      && $stable(repeat_count) && $stable(msg_kind))
    else $error("stalled result item changed");

  // No result item right after reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result item valid right after reset");

  // A complete frame always follows a lead-in, which clears the repeat count.
  a_frame_repeats: assert property (@(posedge clk) disable iff (rst)
    out_valid && (msg_kind == MSG_FRAME) |-> (repeat_count == '0))
    else $error("frame item with nonzero repeat count");

  // A bit is either received or flagged bad, never both.
  a_bits_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((address & address_err) == '0)
      && ((address_inv & address_inv_err) == '0)
      && ((command & command_err) == '0)
      && ((command_inv & command_inv_err) == '0))
    else $error("data bit and error bit both set");

endmodule

bind nec_ir_frame_decoder nir_checker u_nir_checker (.*);

// ===== dv/nir_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR frame checker
// Watches the configuration, pair and message channels of the decoder, keeps
// its own model of the frame state machine, and compares every message the
// decoder delivers against the oldest predicted one.
// ----------------------------------------------------------------------------
module nir_frame_checker
  import nir_pkg::*;
#(
  parameter int BITS_PER_FIELD = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [TIME_W-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [TIME_W-1:0] start_time,
  input  logic [TIME_W-1:0] mid_time,
  input  logic [TIME_W-1:0] end_time,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              msg_kind,
  input  logic [BYTE_W-1:0] address,
  input  logic [BYTE_W-1:0] address_inv,
  input  logic [BYTE_W-1:0] command,
  input  logic [BYTE_W-1:0] command_inv,
  input  logic [BYTE_W-1:0] repeat_count,
  input  logic [BYTE_W-1:0] address_err,
  input  logic [BYTE_W-1:0] address_inv_err,
  input  logic [BYTE_W-1:0] command_err,
  input  logic [BYTE_W-1:0] command_inv_err,
  output int                fail_count,
  output int                pending,
  output int                frames_seen,
  output int                repeats_seen
);

  typedef enum logic [2:0] {
    WAIT_LEAD,
    RX_ADDR,
    RX_ADDR_INV,
    RX_CMD,
    RX_CMD_INV
  } rx_phase_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] address;
    logic [BYTE_W-1:0] address_inv;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] command_inv;
    logic [BYTE_W-1:0] repeat_count;
    logic [BYTE_W-1:0] address_err;
    logic [BYTE_W-1:0] address_inv_err;
    logic [BYTE_W-1:0] command_err;
    logic [BYTE_W-1:0] command_inv_err;
  } nec_msg_t;

  logic [TIME_W-1:0]    wrap_period;
  logic [CLK_W-1:0]     ticks_per_us;
  rx_phase_t            rx_phase;
  logic [BIT_IDX_W-1:0] bit_pos;
  logic [BYTE_W-1:0]    msg_byte [4];
  logic [BYTE_W-1:0]    msg_err [4];
  logic [BYTE_W-1:0]    repeats;
  nec_msg_t             pending_msgs [$];

  function automatic logic [TIME_W-1:0] span_us(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] ticks;
    logic [TIME_W-1:0] div;
    div = (ticks_per_us == '0) ? 32'd1 : 32'(ticks_per_us);
    if (a > b) begin
      ticks = wrap_period - a + b;
    end else begin
      ticks = b - a;
    end
    return ticks / div;
  endfunction

  function automatic logic within_open(input logic [TIME_W-1:0] v,
                                       input logic [TIME_W-1:0] lo,
                                       input logic [TIME_W-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

  function automatic sym_cls_t classify(input logic [TIME_W-1:0] mark_us,
                                        input logic [TIME_W-1:0] space_us);
    if (within_open(mark_us, LEAD_MARK_LO, LEAD_MARK_HI)) begin
      if (within_open(space_us, LEAD_SPACE_LO, LEAD_SPACE_HI)) return CLS_LEADIN;
      if (within_open(space_us, REP_SPACE_LO, REP_SPACE_HI)) return CLS_REPEAT;
    end else if (within_open(mark_us, BIT_SHORT_LO, BIT_SHORT_HI)) begin
      if (within_open(space_us, BIT_LONG_LO, BIT_LONG_HI)) return CLS_ONE;
      if (within_open(space_us, BIT_SHORT_LO, BIT_SHORT_HI)) return CLS_ZERO;
    end
    return CLS_OTHER;
  endfunction

  function automatic nec_msg_t pack_msg(input logic kind);
    nec_msg_t m;
    m.kind            = kind;
    m.address         = msg_byte[0];
    m.address_inv     = msg_byte[1];
    m.command         = msg_byte[2];
    m.command_inv     = msg_byte[3];
    m.repeat_count    = repeats;
    m.address_err     = msg_err[0];
    m.address_inv_err = msg_err[1];
    m.command_err     = msg_err[2];
    m.command_inv_err = msg_err[3];
    return m;
  endfunction

  task automatic clear_msg();
    for (int i = 0; i < 4; i++) begin
      msg_byte[i] = '0;
      msg_err[i]  = '0;
    end
    repeats = '0;
  endtask

  task automatic decode_pair(input logic [TIME_W-1:0] t0,
                             input logic [TIME_W-1:0] t1,
                             input logic [TIME_W-1:0] t2);
    sym_cls_t cls;
    int       fld;
    cls = classify(span_us(t0, t1), span_us(t1, t2));
    if (rx_phase == WAIT_LEAD) begin
      if (cls == CLS_LEADIN) begin
        clear_msg();
        bit_pos  = '0;
        rx_phase = RX_ADDR;
      end else if (cls == CLS_REPEAT) begin
        if (repeats != 8'hFF) repeats = repeats + 8'd1;
        pending_msgs.push_back(pack_msg(MSG_REPEAT));
      end
    end else begin
      fld = int'(rx_phase) - 1;
      if (cls == CLS_ONE) begin
        msg_byte[fld][bit_pos] = 1'b1;
      end else if (cls != CLS_ZERO) begin
        msg_err[fld][bit_pos] = 1'b1;
      end
      if (int'(bit_pos) + 1 >= BITS_PER_FIELD) begin
        bit_pos = '0;
        case (rx_phase)
          RX_ADDR:     rx_phase = RX_ADDR_INV;
          RX_ADDR_INV: rx_phase = RX_CMD;
          RX_CMD:      rx_phase = RX_CMD_INV;
          default: begin
            rx_phase = WAIT_LEAD;
            pending_msgs.push_back(pack_msg(MSG_FRAME));
          end
        endcase
      end else begin
        bit_pos = bit_pos + 1'b1;
      end
    end
  endtask

  task automatic check_byte(input string name, input logic [BYTE_W-1:0] exp_v,
                            input logic [BYTE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_msg();
    nec_msg_t e;
    if (pending_msgs.size() == 0) begin
      $error("Message delivered with no item predicted to cause it.");
      fail_count++;
    end else begin
      e = pending_msgs.pop_front();
      if (e.kind == MSG_REPEAT) repeats_seen++;
      else frames_seen++;
      check_byte("msg_kind", 8'(e.kind), 8'(msg_kind));
      check_byte("address", e.address, address);
      check_byte("address_inv", e.address_inv, address_inv);
      check_byte("command", e.command, command);
      check_byte("command_inv", e.command_inv, command_inv);
      check_byte("repeat_count", e.repeat_count, repeat_count);
      check_byte("address_err", e.address_err, address_err);
      check_byte("address_inv_err", e.address_inv_err, address_inv_err);
      check_byte("command_err", e.command_err, command_err);
      check_byte("command_inv_err", e.command_inv_err, command_inv_err);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wrap_period  = TIMER_PERIOD_RST;
      ticks_per_us = CLOCK_SPEED_RST;
      rx_phase     = WAIT_LEAD;
      bit_pos      = '0;
      clear_msg();
      pending_msgs.delete();
      fail_count   = 0;
      frames_seen  = 0;
      repeats_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TIMER_PERIOD: wrap_period = cfg_data;
          default:          ticks_per_us = cfg_data[CLK_W-1:0];
        endcase
      end
      if (out_valid && !out_stall) check_msg();
      if (in_valid && !in_stall) decode_pair(start_time, mid_time, end_time);
    end
    pending = pending_msgs.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR frame decoder testbench
// Drives mark/space items built from timer captures under several timer
// settings, with bursty input and a stalling receiver; a separate checker
// predicts and compares every message.
// ----------------------------------------------------------------------------
module tb
  import nir_pkg::*;
();

  localparam int N_SETTINGS = 6;
  localparam int SETTLE_CYCLES = 200;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = REG_TIMER_PERIOD;
  logic [TIME_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TIME_W-1:0] start_time = '0;
  logic [TIME_W-1:0] mid_time = '0;
  logic [TIME_W-1:0] end_time = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              msg_kind;
  logic [BYTE_W-1:0] address;
  logic [BYTE_W-1:0] address_inv;
  logic [BYTE_W-1:0] command;
  logic [BYTE_W-1:0] command_inv;
  logic [BYTE_W-1:0] repeat_count;
  logic [BYTE_W-1:0] address_err;
  logic [BYTE_W-1:0] address_inv_err;
  logic [BYTE_W-1:0] command_err;
  logic [BYTE_W-1:0] command_inv_err;
  int                fail_count;
  int                pending;
  int                frames_seen;
  int                repeats_seen;

  logic [TIME_W-1:0] cur_period = TIMER_PERIOD_RST;
  logic [CLK_W-1:0]  cur_speed = CLOCK_SPEED_RST;
  logic [TIME_W-1:0] stamp = '0;
  int                items_sent = 0;
  int                burst_left = 0;
  int                stall_left = 0;
  int                stall_mode = 0;

  nec_ir_frame_decoder dut (.*);
  nir_frame_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver alternates between flowing freely, stalling at random and
  // stalling solidly for a while.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(2, 0);
      stall_left = (stall_mode == 2) ? $urandom_range(60, 1) : $urandom_range(300, 50);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(2, 0) == 0);
      default: out_stall <= 1'b1;
    endcase
  end

  initial begin
    #25_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [TIME_W-1:0] advance(input logic [TIME_W-1:0] t,
                                                input int unsigned us);
    logic [63:0] ticks;
    ticks = 64'(us) * 64'(cur_speed) + 64'($urandom_range(32'(cur_speed) - 1, 0));
    return 32'((64'(t) + ticks) % 64'(cur_period));
  endfunction

  task automatic send_pair(input logic [TIME_W-1:0] t0, input logic [TIME_W-1:0] t1,
                           input logic [TIME_W-1:0] t2);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(60, 1)) @(negedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 40)
                                               : $urandom_range(12, 1);
    end
    burst_left--;
    in_valid   <= 1'b1;
    start_time <= t0;
    mid_time   <= t1;
    end_time   <= t2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_timed(input int unsigned mark_us, input int unsigned space_us);
    logic [TIME_W-1:0] t1;
    logic [TIME_W-1:0] t2;
    t1 = advance(stamp, mark_us);
    t2 = advance(t1, space_us);
    send_pair(stamp, t1, t2);
    stamp = t2;
  endtask

  task automatic send_lead();
    send_timed($urandom_range(9249, 8751), $urandom_range(4749, 4251));
  endtask

  task automatic send_repeat();
    send_timed($urandom_range(9249, 8751), $urandom_range(2749, 2251));
  endtask

  task automatic send_data_bit();
    int unsigned m;
    int unsigned s;
    case ($urandom_range(19, 0))
      0: begin m = 500; s = 1650; end
      1: begin m = 600; s = 550; end
      2: begin
        m = 550;
        s = $urandom_range(1, 0) ? ($urandom_range(1, 0) ? 500 : 600)
                                 : ($urandom_range(1, 0) ? 1500 : 1800);
      end
      3: begin m = 9000; s = 4500; end
      4: begin m = $urandom_range(12000, 0); s = $urandom_range(12000, 0); end
      5: begin m = 550; s = $urandom_range(1499, 601); end
      default: begin
        m = $urandom_range(599, 501);
        s = $urandom_range(1, 0) ? $urandom_range(1799, 1501) : $urandom_range(599, 501);
      end
    endcase
    send_timed(m, s);
  endtask

  task automatic send_frame(input int n_repeats);
    send_lead();
    repeat (32) send_data_bit();
    repeat (n_repeats) send_repeat();
  endtask

  // Holds input off until every predicted message is out and the pipeline has
  // had time to drain items that produce nothing.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [TIME_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_directed();
    send_pair(32'd0, 32'd9000, 32'd11500);
    send_pair(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_pair(32'd0, 32'd0, 32'd0);
    send_pair(32'd100, 32'd8850, 32'd13350);
    send_pair(32'd100, 32'd9350, 32'd13850);
    send_pair(32'd0, 32'd9000, 32'd13250);
    send_pair(32'd0, 32'd9000, 32'd13750);
    send_pair(32'd0, 32'd9000, 32'd11250);
    send_pair(32'd0, 32'd9000, 32'd11750);
    send_pair(32'd65000, 32'd8464, 32'd10964);
    send_pair(32'd0, 32'd8751, 32'd13500);
    send_pair(32'd0, 32'd500, 32'd2000);
    send_pair(32'd0, 32'd599, 32'd2398);
    send_pair(32'd0, 32'd501, 32'd1002);
    send_pair(32'd0, 32'd9000, 32'd13500);
    send_pair(32'd0, 32'd550, 32'd2350);
    send_pair(32'd0, 32'd550, 32'd1100);
    send_pair(32'd0, 32'd600, 32'd1200);
  endtask

  initial begin
    logic [TIME_W-1:0] set_period [N_SETTINGS];
    logic [CLK_W-1:0]  set_speed [N_SETTINGS];
    int                set_quota [N_SETTINGS];
    logic [TIME_W-1:0] speed_word;
    int                quota_end;
    int                pick;

    set_period = '{TIMER_PERIOD_RST, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd20000, 32'd0};
    set_speed  = '{CLOCK_SPEED_RST, 8'd255, 8'd1, 8'd0, 8'd1, 8'd0};
    set_quota  = '{350, 330, 60, 270, 200, 200};
    for (int i = 3; i < N_SETTINGS; i += 2) begin
      set_period[i] = $urandom_range(32'hFFFF_FFFF, 32'h0040_0000);
      set_speed[i]  = $urandom_range(255, 1);
    end

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    quota_end = 0;
    for (int p = 0; p < N_SETTINGS; p++) begin
      if (p != 0) begin
        quiesce();
        write_reg(REG_TIMER_PERIOD, set_period[p]);
        speed_word = $urandom;
        speed_word[CLK_W-1:0] = set_speed[p];
        write_reg(REG_CLOCK_SPEED, speed_word);
      end
      cur_period = set_period[p];
      cur_speed  = set_speed[p];
      stamp      = $urandom % cur_period;
      quota_end += set_quota[p];
      if (p == 0) send_directed();
      if (p == 1) begin
        // A long run of repeat codes drives the counter into saturation.
        send_frame(0);
        repeat (262) send_repeat();
      end
      while (items_sent < quota_end) begin
        pick = $urandom_range(99, 0);
        if (pick < 65) begin
          send_frame(($urandom_range(3, 0) == 0) ? $urandom_range(4, 1) : 0);
        end else if (pick < 75) begin
          repeat ($urandom_range(3, 1)) send_repeat();
        end else if (pick < 85) begin
          send_pair($urandom, $urandom, $urandom);
        end else if (pick < 92) begin
          send_lead();
          repeat ($urandom_range(31, 1)) send_data_bit();
        end else if (pick < 97) begin
          send_timed($urandom_range(10000, 8000), $urandom_range(5000, 2000));
        end else begin
          quiesce();
        end
      end
    end
    quiesce();

    $display("Sent %0d mark/space items across %0d timer settings, including a saturating",
             items_sent, N_SETTINGS);
    $display("repeat run; checked %0d frame and %0d repeat messages.",
             frames_seen, repeats_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/nir_pkg.sv
design/nir_div.sv
design/nir_front.sv
design/nir_queue.sv
design/nir_back.sv
design/nec_ir_frame_decoder.sv
design/nir_checker.sv
dv/nir_frame_checker.sv
dv/tb.sv
